@@ rtl/core/ssfd_pkg.sv @@
// shared types and constants for the servo status frame deframer
`default_nettype none

package ssfd_pkg;

  // frame marker bytes
  localparam logic [7:0] HDR0_BYTE   = 8'h55;
  localparam logic [7:0] HDR1_BYTE   = 8'h0B;
  localparam logic [7:0] TAIL_BYTE   = 8'hBB;
  localparam logic [8:0] SUM_MODULUS = 9'h0FF;

  // frame type codes
  localparam logic [7:0] TYPE_ANGLE  = 8'h00;
  localparam logic [7:0] TYPE_FINISH = 8'h01;

  // report kinds
  localparam logic KIND_ANGLE  = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // byte positions within a frame
  localparam logic [2:0] POS_HDR0  = 3'd0;
  localparam logic [2:0] POS_HDR1  = 3'd1;
  localparam logic [2:0] POS_TYPE  = 3'd2;
  localparam logic [2:0] POS_ID    = 3'd3;
  localparam logic [2:0] POS_ANGH  = 3'd4;
  localparam logic [2:0] POS_ANGL  = 3'd5;
  localparam logic [2:0] POS_CHK   = 3'd6;
  localparam logic [2:0] POS_TAIL  = 3'd7;

  typedef struct packed {
    logic        kind;
    logic [7:0]  servo_id;
    logic [15:0] angle;
  } report_t;

endpackage

`default_nettype wire

@@ rtl/core/ssfd_frame.sv @@
// frame tracker: byte position, held fields, checksum and report decode
`default_nettype none

module ssfd_frame (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic [7:0]      rx_byte,
  input  wire logic            read_start,
  output logic                 rpt_valid,
  output ssfd_pkg::report_t    rpt
);

  logic [2:0]  pos_r,    pos_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [7:0]  type_r,   type_nxt;
  logic [7:0]  id_r,     id_nxt;
  logic [15:0] angle_r,  angle_nxt;
  logic [7:0]  chk_r,    chk_nxt;
  logic [10:0] sum_r,    sum_nxt;

  logic [2:0]  pos;
  logic [10:0] sum_add;
  logic [8:0]  fold;
  logic [8:0]  fold_red;
  logic [7:0]  sum_mod;
  logic        type_known;

  // total mod 255: fold the top bits onto the low byte, then one correction
  always_comb begin
    sum_add  = sum_r + {3'b000, rx_byte};
    fold     = {6'b000000, sum_add[10:8]} + {1'b0, sum_add[7:0]};
    fold_red = (fold >= ssfd_pkg::SUM_MODULUS) ? (fold - ssfd_pkg::SUM_MODULUS) : fold;
    sum_mod  = fold_red[7:0];
  end

  always_comb begin
    pos        = read_start ? ssfd_pkg::POS_HDR0 : pos_r;
    pos_nxt    = pos + 3'd1;
    hdr_ok_nxt = hdr_ok_r;
    type_nxt   = type_r;
    id_nxt     = id_r;
    angle_nxt  = angle_r;
    chk_nxt    = chk_r;
    sum_nxt    = sum_add;
    rpt_valid  = 1'b0;
    rpt        = '0;
    type_known = (type_r == ssfd_pkg::TYPE_ANGLE) || (type_r == ssfd_pkg::TYPE_FINISH);
    case (pos)
      ssfd_pkg::POS_HDR0: begin
        hdr_ok_nxt = (rx_byte == ssfd_pkg::HDR0_BYTE);
        sum_nxt    = {3'b000, rx_byte};
      end
      ssfd_pkg::POS_HDR1: hdr_ok_nxt = hdr_ok_r && (rx_byte == ssfd_pkg::HDR1_BYTE);
      ssfd_pkg::POS_TYPE: type_nxt = rx_byte;
      ssfd_pkg::POS_ID:   id_nxt = rx_byte;
      ssfd_pkg::POS_ANGH: angle_nxt = {rx_byte, angle_r[7:0]};
      ssfd_pkg::POS_ANGL: angle_nxt = {angle_r[15:8], rx_byte};
      ssfd_pkg::POS_CHK: begin
        chk_nxt = rx_byte;
        sum_nxt = sum_r;
      end
      ssfd_pkg::POS_TAIL: begin
        rpt_valid = hdr_ok_r && (rx_byte == ssfd_pkg::TAIL_BYTE) && (sum_mod == chk_r)
                    && type_known;
        if (type_r == ssfd_pkg::TYPE_ANGLE) begin
          rpt.kind     = ssfd_pkg::KIND_ANGLE;
          rpt.servo_id = id_r;
          rpt.angle    = angle_r;
        end else begin
          rpt.kind = ssfd_pkg::KIND_FINISH;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= ssfd_pkg::POS_HDR0;
      hdr_ok_r <= 1'b0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      hdr_ok_r <= hdr_ok_nxt;
    end
  end

  // field holders need no reset: position 7 is only reached after 0..6 refill them
  always_ff @(posedge clk) begin
    if (step) begin
      type_r  <= type_nxt;
      id_r    <= id_nxt;
      angle_r <= angle_nxt;
      chk_r   <= chk_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/servo_status_frame_deframer.sv @@
// top level: input register, frame tracker and result register
`default_nettype none

// channel   direction  ports                                   meaning
// in_       input      in_rx_byte, in_read_start               one received byte per transfer
// out_      output     out_report_kind, out_servo_id, out_angle one decoded status report
//
// one byte per cycle sustained while out_stall is low; each byte waits in the input register and
// its report, if any, is loaded into the result register when that byte advances
// the byte is decoded when the result register is empty or being drained
// synchronous active-low reset clears frame alignment and both valid flags
// out_stall holds the result register, which in turn holds the input register;
// a new byte is still taken while a report waits as long as the input register is empty

module servo_status_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_read_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_report_kind,
  output logic [7:0]       out_servo_id,
  output logic [15:0]      out_angle
);

  // input register
  logic       in_v_r;
  logic [7:0] byte_r;
  logic       start_r;

  // result register
  logic              out_v_r;
  ssfd_pkg::report_t out_r;

  logic              adv;
  logic              in_take;
  logic              rpt_valid;
  ssfd_pkg::report_t rpt;

  // the held byte moves on when the result register can take a report
  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r  <= in_rx_byte;
      start_r <= in_read_start;
    end
  end

  ssfd_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .rx_byte    (byte_r),
    .read_start (start_r),
    .rpt_valid  (rpt_valid),
    .rpt        (rpt)
  );

  // result register, loaded only by a completed good frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && rpt_valid) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && rpt_valid) begin
      out_r <= rpt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_report_kind = out_r.kind;
  assign out_servo_id    = out_r.servo_id;
  assign out_angle       = out_r.angle;

endmodule

`default_nettype wire
